// ----- rtl/cpbf_pkg.sv -----
`timescale 1ns / 1ps

package cpbf_pkg;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    localparam int OUT_IDX_W = 8;

endpackage

// ----- rtl/cpbf_dist.sv -----
`timescale 1ns / 1ps

module cpbf_dist #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [2*COORD_BITS-1:0] i_pa,
    input  logic [2*COORD_BITS-1:0] i_pb,
    input  logic [IDX_W-1:0]        i_ia,
    input  logic [IDX_W-1:0]        i_ib,
    output logic                    o_valid,
    output logic                    o_busy,
    output logic [2*COORD_BITS+1:0] o_dist,
    output logic [IDX_W-1:0]        o_ia,
    output logic [IDX_W-1:0]        o_ib
);

    localparam int CB = COORD_BITS;
    localparam int SW = 2 * CB + 1;
    localparam int DW = 2 * CB + 2;

    logic [CB-1:0]        ax, ay, bx, by;
    logic signed [CB:0]   dx, dy;
    logic signed [CB:0]   r_dx, r_dy;
    logic signed [DW-1:0] sqx, sqy;
    logic [SW-1:0]        r_sqx, r_sqy;
    logic [DW-1:0]        r_sum;
    logic                 r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]     r_ia1, r_ib1, r_ia2, r_ib2, r_ia3, r_ib3;

    assign ax = i_pa[CB-1:0];
    assign ay = i_pa[2*CB-1:CB];
    assign bx = i_pb[CB-1:0];
    assign by = i_pb[2*CB-1:CB];

    assign dx  = $signed({ax[CB-1], ax}) - $signed({bx[CB-1], bx});
    assign dy  = $signed({ay[CB-1], ay}) - $signed({by[CB-1], by});
    assign sqx = r_dx * r_dx;
    assign sqy = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // difference, square, sum
    always_ff @(posedge i_clk) begin
        r_dx  <= dx;
        r_dy  <= dy;
        r_ia1 <= i_ia;
        r_ib1 <= i_ib;
        r_sqx <= sqx[SW-1:0];
        r_sqy <= sqy[SW-1:0];
        r_ia2 <= r_ia1;
        r_ib2 <= r_ib1;
        r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
        r_ia3 <= r_ia2;
        r_ib3 <= r_ib2;
    end

    assign o_valid = r_v3;
    assign o_busy  = r_v1 | r_v2 | r_v3;
    assign o_dist  = r_sum;
    assign o_ia    = r_ia3;
    assign o_ib    = r_ib3;

endmodule

// ----- rtl/closest_pair_brute_force_unit.sv -----
`timescale 1ns / 1ps
// Closest pair of 2-D points, brute force over all pairs.
// Input stream: one point per beat, x in tdata[15:0], y in tdata[31:16],
// tlast on the final point of a set. Points are written into an on-chip
// point memory; points beyond MAX_POINTS are dropped and flagged.
// The beat with tlast starts the search: every pair i < j is read from
// the memory (two read ports) and fed into one pipelined squared-distance
// unit, one pair per cycle, and a compare stage keeps the smallest one,
// the earlier pair winning a tie.
// With fewer than two stored points the search is skipped. tready is
// low from the tlast beat until the result is written to the output
// register; the next set cannot load while the pair loop through the
// shared distance unit runs.
// Output stream: one beat per set; tdata holds first index, second index
// and the dropped flag; tuser is high when at least two points were given.
// A stalled receiver holds the result; the next set may load meanwhile.
// Reset empties the point set and the output register.
module closest_pair_brute_force_unit
    import cpbf_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // point_x, point_y
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // first_index, second_index, points_dropped
    output logic        o_m_axis_tuser   // pair_valid
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PW    = 2 * COORD_BITS;
    localparam int DW    = 2 * COORD_BITS + 2;

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_drop, n_drop;
    logic [IDX_W-1:0]     r_i, n_i, r_j, n_j;
    logic                 r_first, n_first;
    logic [DW-1:0]        r_best_d, n_best_d;
    logic [IDX_W-1:0]     r_best_first, n_best_first;
    logic [IDX_W-1:0]     r_best_second, n_best_second;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_IDX_W-1:0] r_out_first, n_out_first;
    logic [OUT_IDX_W-1:0] r_out_second, n_out_second;
    logic                 r_out_drop, n_out_drop;
    logic                 r_out_pair, n_out_pair;

    logic [PW-1:0]        r_mem [MAX_POINTS];
    logic [PW-1:0]        r_rd_a, r_rd_b;
    logic [IDX_W-1:0]     r_i1, r_j1;
    logic                 r_v1;

    logic                 s_fire, issue, not_full, out_free, pair_ok;
    logic [PW-1:0]        wr_point;
    logic [IDX_W-1:0]     last_idx;
    logic                 d_valid, d_busy;
    logic [DW-1:0]        d_dist;
    logic [IDX_W-1:0]     d_ia, d_ib;

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign not_full        = (r_count < CNT_W'(MAX_POINTS));
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign pair_ok         = (r_count >= CNT_W'(2));
    assign last_idx        = IDX_W'(r_count - 1'b1);
    assign wr_point        = {COORD_BITS'(i_s_axis_tdata[31:16]),
                              COORD_BITS'(i_s_axis_tdata[15:0])};

    // point memory, two read ports
    always_ff @(posedge i_clk) begin
        if (s_fire && not_full) begin
            r_mem[r_count[IDX_W-1:0]] <= wr_point;
        end
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[r_j];
        r_i1   <= r_i;
        r_j1   <= r_j;
    end

    cpbf_dist #(
        .COORD_BITS(COORD_BITS),
        .IDX_W     (IDX_W)
    ) u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_v1),
        .i_pa   (r_rd_a),
        .i_pb   (r_rd_b),
        .i_ia   (r_i1),
        .i_ib   (r_j1),
        .o_valid(d_valid),
        .o_busy (d_busy),
        .o_dist (d_dist),
        .o_ia   (d_ia),
        .o_ib   (d_ib)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_drop        = r_drop;
        n_i           = r_i;
        n_j           = r_j;
        n_first       = r_first;
        n_best_d      = r_best_d;
        n_best_first  = r_best_first;
        n_best_second = r_best_second;
        n_out_valid   = r_out_valid;
        n_out_first   = r_out_first;
        n_out_second  = r_out_second;
        n_out_drop    = r_out_drop;
        n_out_pair    = r_out_pair;
        issue         = 1'b0;

        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // running minimum, first pair taken as is
        if (d_valid) begin
            if (r_first || (d_dist < r_best_d)) begin
                n_best_d      = d_dist;
                n_best_first  = d_ia;
                n_best_second = d_ib;
            end
            n_first = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (s_fire) begin
                    if (not_full) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        if (n_count >= CNT_W'(2)) begin
                            n_state = ST_SCAN;
                            n_i     = '0;
                            n_j     = IDX_W'(1);
                            n_first = 1'b1;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end
                end
            end
            ST_SCAN: begin
                issue = 1'b1;
                if (r_j == last_idx) begin
                    if (r_i == IDX_W'(last_idx - 1'b1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_i = IDX_W'(r_i + 1'b1);
                        n_j = IDX_W'(r_i + 2'd2);
                    end
                end else begin
                    n_j = IDX_W'(r_j + 1'b1);
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !d_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_first  = pair_ok ? OUT_IDX_W'(r_best_first) : '0;
                    n_out_second = pair_ok ? OUT_IDX_W'(r_best_second) : '0;
                    n_out_pair   = pair_ok;
                    n_out_drop   = r_drop;
                    n_count      = '0;
                    n_drop       = 1'b0;
                    n_state      = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_LOAD;
            r_count       <= '0;
            r_drop        <= 1'b0;
            r_i           <= '0;
            r_j           <= '0;
            r_first       <= 1'b0;
            r_v1          <= 1'b0;
            r_best_d      <= '0;
            r_best_first  <= '0;
            r_best_second <= IDX_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_drop        <= n_drop;
            r_i           <= n_i;
            r_j           <= n_j;
            r_first       <= n_first;
            r_v1          <= issue;
            r_best_d      <= n_best_d;
            r_best_first  <= n_best_first;
            r_best_second <= n_best_second;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_drop   <= n_out_drop;
        r_out_pair   <= n_out_pair;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_drop, r_out_second, r_out_first};
    assign o_m_axis_tuser  = r_out_pair;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_i < r_j) && (r_j <= last_idx)))
        else $error("pair indices out of order");

    a_pipe_idle_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (!r_v1 && !d_busy))
        else $error("distance pipeline busy while loading");

    a_best_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && pair_ok) |-> (r_best_first < r_best_second))
        else $error("best pair indices out of order");

    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && out_free) |=> (o_m_axis_tvalid && (r_count == '0)))
        else $error("result not written on finish");

endmodule
